// ===== rtl/core/banned_word_matcher_macros.svh =====
// Assertion helpers shared by the matcher checks.
`ifndef BANNED_WORD_MATCHER_MACROS_SVH
`define BANNED_WORD_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("banned_word_matcher check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("banned_word_matcher check failed");

`endif

// ===== rtl/core/bwm_pkg.sv =====
`default_nettype none

package bwm_pkg;

  typedef enum logic [1:0] {
    OP_WR_BYTE = 2'd0,
    OP_SET_LEN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_END     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN
  } state_e;

  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5A;
  localparam logic [7:0] CHAR_LO_A = 8'h61;

  // window cell control
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  // table requests from the sequencer
  typedef struct packed {
    logic byte_we;
    logic len_we;
    logic rd_en;
  } tbl_ctl_t;

  // table status back to the sequencer
  typedef struct packed {
    logic clr_busy;
    logic rd_pend;
    logic cmp_vld;
    logic len_nz;
  } tbl_sts_t;

  // ASCII A-Z to lower case, everything else unchanged
  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
      r = b - CHAR_UP_A + CHAR_LO_A;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/banned_word_matcher.sv =====
// banned_word_matcher: case-insensitive search of a text stream for any of a
// table of banned words.
// Input channel (in_valid_i / in_stall_o) carries one word per item: write a
// word byte, set a word length, a text byte, or end of text. The output
// channel (out_valid_o / out_stall_i) returns one word, blocked_o, per end of
// text. cfg_we_i / cfg_wdata_i set the number of words taking part.
// Table writes and end of text are taken in the idle state. For a text byte,
// each active word row is read from the table once, aligned, then compared
// by the row of window cells; the table read port sets the rate.
// The result word appears in the output register the cycle after end of text
// is taken. While it waits under out_stall_i, loads and text bytes are still
// taken; another end of text is held off until the output register empties.
// After reset the length table is swept to zero, and in_stall_o stays high
// while the sweep runs; configuration writes are taken throughout.
`default_nettype none

module banned_word_matcher #(
  parameter int MAX_WORDS = 64,
  parameter int MAX_LEN   = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [5:0] word_index_i,
  input  wire logic [4:0] position_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic [4:0] word_length_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            blocked_o
);

  localparam int SLOTS = MAX_LEN - 1;
  localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW    = $clog2(MAX_WORDS + 1);

  bwm_pkg::state_e       state_q, state_d;
  logic [6:0]            act_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         n_q, n_d;
  logic [CW-1:0]         n_eff;
  logic                  hit_q, hit_d;
  logic                  out_vld_q, out_vld_d;
  logic                  blk_q, blk_d;
  logic                  issuing;
  logic                  all_ok;

  bwm_pkg::win_ctl_t     win_ctl;
  bwm_pkg::tbl_ctl_t     tbl_ctl;
  bwm_pkg::tbl_sts_t     tbl_sts;
  logic [SLOTS-1:0][7:0] word_al;
  logic [SLOTS-1:0]      care;
  logic [7:0]            cell_byte_in [SLOTS];
  logic                  cell_vld_in  [SLOTS];
  logic [7:0]            cell_byte    [SLOTS];
  logic                  cell_vld     [SLOTS];
  logic [SLOTS-1:0]      cell_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else if (cfg_we_i) begin
      act_q <= cfg_wdata_i;
    end
  end

  assign n_eff   = (32'(act_q) > MAX_WORDS) ? CW'(MAX_WORDS) : CW'(act_q);
  assign issuing = cnt_q < n_q;
  assign all_ok  = &cell_ok;

  bwm_table #(
    .MAX_WORDS(MAX_WORDS),
    .MAX_LEN  (MAX_LEN)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (tbl_ctl),
    .word_index_i (word_index_i),
    .position_i   (position_i),
    .byte_value_i (byte_value_i),
    .word_length_i(word_length_i),
    .rd_addr_i    (cnt_q[AW-1:0]),
    .sts_o        (tbl_sts),
    .word_o       (word_al),
    .care_o       (care)
  );

  // window chain: new folded byte enters at the tail, oldest leaves at lane 0
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == SLOTS - 1) begin : g_tail
      assign cell_byte_in[k] = bwm_pkg::fold(byte_value_i);
      assign cell_vld_in[k]  = 1'b1;
    end else begin : g_body
      assign cell_byte_in[k] = cell_byte[k+1];
      assign cell_vld_in[k]  = cell_vld[k+1];
    end

    bwm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (win_ctl),
      .byte_i     (cell_byte_in[k]),
      .vld_i      (cell_vld_in[k]),
      .word_byte_i(word_al[k]),
      .care_i     (care[k]),
      .byte_o     (cell_byte[k]),
      .vld_o      (cell_vld[k]),
      .ok_o       (cell_ok[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bwm_pkg::ST_INIT;
      cnt_q     <= '0;
      n_q       <= '0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
      blk_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      hit_q     <= hit_d;
      out_vld_q <= out_vld_d;
      blk_q     <= blk_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    hit_d      = hit_q;
    out_vld_d  = out_vld_q;
    blk_d      = blk_q;
    in_stall_o = 1'b1;
    win_ctl    = '0;
    tbl_ctl    = '0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (tbl_sts.cmp_vld && tbl_sts.len_nz && all_ok) begin
      hit_d = 1'b1;
    end

    case (state_q)
      bwm_pkg::ST_INIT: begin
        if (!tbl_sts.clr_busy) begin
          state_d = bwm_pkg::ST_IDLE;
        end
      end
      bwm_pkg::ST_IDLE: begin
        in_stall_o = out_vld_q && (operation_i == bwm_pkg::OP_END);
        if (in_valid_i && !in_stall_o) begin
          case (bwm_pkg::op_e'(operation_i))
            bwm_pkg::OP_WR_BYTE: tbl_ctl.byte_we = 1'b1;
            bwm_pkg::OP_SET_LEN: tbl_ctl.len_we = 1'b1;
            bwm_pkg::OP_TEXT: begin
              win_ctl.shift = 1'b1;
              n_d           = n_eff;
              cnt_d         = '0;
              state_d       = bwm_pkg::ST_SCAN;
            end
            bwm_pkg::OP_END: begin
              win_ctl.clear = 1'b1;
              blk_d         = hit_q;
              hit_d         = 1'b0;
              out_vld_d     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      bwm_pkg::ST_SCAN: begin
        tbl_ctl.rd_en = issuing;
        if (issuing) begin
          cnt_d = cnt_q + CW'(1);
        end
        // last compare, if any, lands in hit_q on this same edge
        if (!issuing && !tbl_sts.rd_pend) begin
          state_d = bwm_pkg::ST_IDLE;
        end
      end
      default: state_d = bwm_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign blocked_o   = blk_q;

endmodule

`default_nettype wire

// ===== rtl/core/bwm_cell.sv =====
`default_nettype none

// One window byte: shifts toward lower index, compares against its lane of the word.
module bwm_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bwm_pkg::win_ctl_t ctl_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              vld_i,
  input  wire logic [7:0]        word_byte_i,
  input  wire logic              care_i,
  output logic [7:0]             byte_o,
  output logic                   vld_o,
  output logic                   ok_o
);

  logic [7:0] byte_q;
  logic       vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctl_i.shift) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  assign vld_o  = vld_q;
  assign ok_o   = !care_i || (vld_q && (byte_q == bwm_pkg::fold(word_byte_i)));

endmodule

`default_nettype wire

// ===== rtl/core/bwm_table.sv =====
`default_nettype none

// Word byte rows and word lengths. Reads go through two registered stages:
// row fetch, then right alignment of the word against the window tail.
module bwm_table #(
  parameter int MAX_WORDS = 64,
  parameter int MAX_LEN   = 32,
  localparam int SLOTS    = MAX_LEN - 1,
  localparam int AW       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int PW       = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int LW       = $clog2(MAX_LEN)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bwm_pkg::tbl_ctl_t       ctl_i,
  input  wire logic [5:0]              word_index_i,
  input  wire logic [4:0]              position_i,
  input  wire logic [7:0]              byte_value_i,
  input  wire logic [4:0]              word_length_i,
  input  wire logic [AW-1:0]           rd_addr_i,
  output bwm_pkg::tbl_sts_t            sts_o,
  output logic [SLOTS-1:0][7:0]        word_o,
  output logic [SLOTS-1:0]             care_o
);

  logic [SLOTS-1:0][7:0] row_mem [MAX_WORDS];
  logic [LW-1:0]         len_mem [MAX_WORDS];

  logic                  clr_busy_q;
  logic [AW-1:0]         clr_addr_q;
  logic                  idx_ok;
  logic                  pos_ok;
  logic [AW-1:0]         wr_addr;
  logic [PW-1:0]         wr_lane;
  logic [LW-1:0]         len_sat;

  logic                  v1_q, v2_q;
  logic [SLOTS-1:0][7:0] row_q;
  logic [LW-1:0]         len_q;
  logic [LW-1:0]         skip;
  logic [SLOTS-1:0][7:0] word_q;
  logic [SLOTS-1:0]      care_q;
  logic                  lnz_q;

  assign idx_ok  = 32'(word_index_i) < MAX_WORDS;
  assign pos_ok  = 32'(position_i) < SLOTS;
  assign wr_addr = AW'(word_index_i);
  assign wr_lane = PW'(position_i);
  assign len_sat = (32'(word_length_i) > SLOTS) ? LW'(SLOTS) : LW'(word_length_i);

  // length clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (32'(clr_addr_q) == MAX_WORDS - 1) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.byte_we && idx_ok && pos_ok) begin
      row_mem[wr_addr][wr_lane] <= byte_value_i;
    end
    if (ctl_i.rd_en) begin
      row_q <= row_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      len_mem[clr_addr_q] <= '0;
    end else if (ctl_i.len_we && idx_ok) begin
      len_mem[wr_addr] <= len_sat;
    end
    if (ctl_i.rd_en) begin
      len_q <= len_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.rd_en;
      v2_q <= v1_q;
    end
  end

  // word byte j lands on window lane SLOTS-len+j
  assign skip = LW'(SLOTS) - len_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      word_q <= row_q << {skip, 3'b000};
      care_q <= {SLOTS{1'b1}} << skip;
      lnz_q  <= len_q != '0;
    end
  end

  assign sts_o.clr_busy = clr_busy_q;
  assign sts_o.rd_pend  = v1_q;
  assign sts_o.cmp_vld  = v2_q;
  assign sts_o.len_nz   = lnz_q;
  assign word_o         = word_q;
  assign care_o         = care_q;

endmodule

`default_nettype wire

// ===== rtl/core/bwm_checker.sv =====
`default_nettype none

`include "banned_word_matcher_macros.svh"

module bwm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] operation_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       blocked_o
);

  `BWM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(blocked_o))

  // single result register: empties in the cycle after an unstalled output
  `BWM_ASSERT_NEXT(a_out_drain, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o)

  `BWM_ASSERT_NOW(a_out_cause, clk_i, rst_ni, $rose(out_valid_o),
    $past(in_valid_i && !in_stall_o && operation_i == bwm_pkg::OP_END))

  // a text byte always starts a scan that holds off the next word
  `BWM_ASSERT_NEXT(a_text_busy, clk_i, rst_ni,
    in_valid_i && !in_stall_o && operation_i == bwm_pkg::OP_TEXT, in_stall_o)

endmodule

bind banned_word_matcher bwm_checker u_bwm_checker (.*);

`default_nettype wire
